[sv/bbl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbl_pkg
// shared types, widths and tables of the horizontal box blur
// ----------------------------------------------------------------------------
package bbl_pkg;

	localparam int PIX_W        = 32;
	localparam int CH_W         = 8;
	localparam int NUM_CH       = 4;
	localparam int SUM_W        = 14;
	localparam int DIST_CFG_W   = 5;
	localparam int MAX_DISTANCE = 16;
	localparam int STORE_DEPTH  = 2 * MAX_DISTANCE + 1;
	localparam int ADDR_W       = $clog2(STORE_DEPTH);
	localparam int D_W          = $clog2(MAX_DISTANCE + 1);
	localparam int CNT_W        = D_W + 1;
	localparam int RCP_W        = 21;
	localparam int RCP_SH       = 20;
	localparam int PROD_W       = SUM_W + RCP_W;
	localparam int PADDR_W      = 3;

	// register select bit of paddr
	localparam logic REG_DIST   = 1'b0;
	localparam logic REG_BORDER = 1'b1;

	typedef logic [NUM_CH-1:0][SUM_W-1:0] sum_vec_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_FLUSH = 2'b10
	} seq_state_t;

	// one window shift on its way from the sequencer to the sum update
	typedef struct packed {
		logic              vld;
		logic [PIX_W-1:0]  pix;
		logic              ls;
		sum_vec_t          init;
		logic              old_ok;
		logic [PIX_W-1:0]  old_sub;
		logic              fwd;
		logic [PIX_W-1:0]  fwd_pix;
		logic              emit;
		logic              last;
		logic              lil;
		logic              lif;
		logic [ADDR_W-1:0] wr_addr;
	} shift_t;

	// one result on its way to the averaging stage
	typedef struct packed {
		logic             vld;
		sum_vec_t         sum;
		logic [PIX_W-1:0] pix;
		logic             last;
		logic             lil;
		logic             lif;
	} avg_req_t;

	function automatic logic [CH_W-1:0] chan(logic [PIX_W-1:0] p, logic [1:0] k);
		return p[CH_W*k +: CH_W];
	endfunction

	function automatic logic [D_W-1:0] sat_dist(logic [DIST_CFG_W-1:0] v);
		if (int'(v) > MAX_DISTANCE)
			return D_W'(MAX_DISTANCE);
		else
			return D_W'(v);
	endfunction

	// ceil(2^RCP_SH / (2*d+1)); floor(sum * r >> RCP_SH) is exact for 14-bit sums
	function automatic logic [RCP_W-1:0] recip(logic [D_W-1:0] d);
		logic [RCP_W-1:0] r;
		case (d)
			D_W'(0):  r = RCP_W'(1048576);
			D_W'(1):  r = RCP_W'(349526);
			D_W'(2):  r = RCP_W'(209716);
			D_W'(3):  r = RCP_W'(149797);
			D_W'(4):  r = RCP_W'(116509);
			D_W'(5):  r = RCP_W'(95326);
			D_W'(6):  r = RCP_W'(80660);
			D_W'(7):  r = RCP_W'(69906);
			D_W'(8):  r = RCP_W'(61681);
			D_W'(9):  r = RCP_W'(55189);
			D_W'(10): r = RCP_W'(49933);
			D_W'(11): r = RCP_W'(45591);
			D_W'(12): r = RCP_W'(41944);
			D_W'(13): r = RCP_W'(38837);
			D_W'(14): r = RCP_W'(36158);
			D_W'(15): r = RCP_W'(33826);
			D_W'(16): r = RCP_W'(31776);
			default:  r = RCP_W'(31776);
		endcase
		return r;
	endfunction

endpackage

[sv/bbl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbl_ram
// simple dual port ram, one write and one registered read port
// ----------------------------------------------------------------------------
module bbl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 33
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// read returns old data on a same-address write
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem[rd_addr];
	end

endmodule

[sv/bbl_seq.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbl_seq
// item intake, flush sequencing and window address generation
// ----------------------------------------------------------------------------
module bbl_seq import bbl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [D_W-1:0]    blur_dist,
	input  logic [PIX_W-1:0]  border,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [PIX_W-1:0]  pixel_in,
	input  logic              last_in_line,
	input  logic              last_in_frame,
	output logic [ADDR_W-1:0] rd_addr,
	output shift_t            shift_s1
);

	seq_state_t        state_q;
	logic [D_W-1:0]    cnt_q;
	logic              lif_q;
	logic              line_start_q;
	logic [PIX_W-1:0]  border_ls_q;
	logic [D_W-1:0]    seen_q;
	logic [CNT_W-1:0]  fill_q;
	logic [ADDR_W-1:0] wp_q;

	logic              is_pix;
	logic              issue;
	logic              ls;
	logic [CNT_W-1:0]  w;
	logic [CNT_W-1:0]  fc;
	logic [D_W-1:0]    ps;
	logic [ADDR_W:0]   back;
	logic              flush_next;
	shift_t            sh;

	assign is_pix   = (state_q == S_IDLE);
	assign in_ready = en && is_pix;
	assign issue    = en && ((is_pix && in_valid) || (state_q == S_FLUSH));
	assign ls       = is_pix && line_start_q;
	assign w        = {blur_dist, 1'b1};
	assign fc       = ls ? '0 : fill_q;
	assign ps       = ls ? '0 : seen_q;
	assign flush_next = last_in_line && (blur_dist != '0);

	// entry that drops out of the window: w places behind the write pointer
	always_comb begin
		back = {1'b0, wp_q} + (ADDR_W+1)'(STORE_DEPTH) - (ADDR_W+1)'(w);
		if (back >= (ADDR_W+1)'(STORE_DEPTH))
			rd_addr = ADDR_W'(back - (ADDR_W+1)'(STORE_DEPTH));
		else
			rd_addr = ADDR_W'(back);
	end

	always_comb begin
		sh         = '0;
		sh.vld     = 1'b1;
		sh.pix     = is_pix ? pixel_in : border;
		sh.ls      = ls;
		for (int k = 0; k < NUM_CH; k++)
			sh.init[k] = SUM_W'(chan(border, 2'(k))) * SUM_W'(w);
		sh.old_ok  = (fc >= w);
		sh.old_sub = ls ? border : border_ls_q;
		sh.fwd     = shift_s1.vld && (rd_addr == shift_s1.wr_addr);
		sh.fwd_pix = shift_s1.pix;
		sh.emit    = (ps >= blur_dist);
		sh.last    = is_pix ? !flush_next : (cnt_q == D_W'(1));
		sh.lil     = is_pix ? last_in_line : 1'b1;
		sh.lif     = is_pix ? last_in_frame : lif_q;
		sh.wr_addr = wp_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			lif_q        <= 1'b0;
			line_start_q <= 1'b1;
			border_ls_q  <= '0;
			seen_q       <= '0;
			fill_q       <= '0;
			wp_q         <= '0;
			shift_s1     <= '0;
		end else if (en) begin
			shift_s1 <= issue ? sh : '0;
			if (issue) begin
				if (ls)
					border_ls_q <= border;
				seen_q <= (ps < blur_dist) ? ps + D_W'(1) : ps;
				fill_q <= (fc < CNT_W'(STORE_DEPTH)) ? fc + CNT_W'(1) : fc;
				wp_q   <= (wp_q == ADDR_W'(STORE_DEPTH - 1)) ? '0 : wp_q + ADDR_W'(1);
				case (state_q)
					S_IDLE: begin
						// a line ends here unless a border flush follows
						line_start_q <= last_in_line && !flush_next;
						if (flush_next) begin
							state_q <= S_FLUSH;
							cnt_q   <= blur_dist;
							lif_q   <= last_in_frame;
						end
					end
					S_FLUSH: begin
						cnt_q <= cnt_q - D_W'(1);
						if (cnt_q == D_W'(1)) begin
							state_q      <= S_IDLE;
							line_start_q <= 1'b1;
						end
					end
					default: state_q <= S_IDLE;
				endcase
			end
		end
	end

endmodule

[sv/bbl_sum.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbl_sum
// running channel sums and window write back
// ----------------------------------------------------------------------------
module bbl_sum import bbl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  shift_t            shift_s1,
	input  logic [PIX_W-1:0]  rd_data,
	output logic              wr_en,
	output logic [ADDR_W-1:0] wr_addr,
	output logic [PIX_W-1:0]  wr_data,
	output avg_req_t          avg_s2
);

	sum_vec_t         sum_q;
	sum_vec_t         base;
	sum_vec_t         nsum;
	logic [PIX_W-1:0] old;

	// entries not yet written in this line read as the line's border
	always_comb begin
		if (!shift_s1.old_ok)
			old = shift_s1.old_sub;
		else if (shift_s1.fwd)
			old = shift_s1.fwd_pix;
		else
			old = rd_data;
		base = shift_s1.ls ? shift_s1.init : sum_q;
		for (int k = 0; k < NUM_CH; k++)
			nsum[k] = base[k] + SUM_W'(chan(shift_s1.pix, 2'(k)))
				- SUM_W'(chan(old, 2'(k)));
	end

	assign wr_en   = en && shift_s1.vld;
	assign wr_addr = shift_s1.wr_addr;
	assign wr_data = shift_s1.pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q  <= '0;
			avg_s2 <= '0;
		end else if (en) begin
			if (shift_s1.vld)
				sum_q <= nsum;
			avg_s2.vld  <= shift_s1.vld && shift_s1.emit;
			avg_s2.sum  <= nsum;
			avg_s2.pix  <= shift_s1.pix;
			avg_s2.last <= shift_s1.last;
			avg_s2.lil  <= shift_s1.lil;
			avg_s2.lif  <= shift_s1.lif;
		end
	end

endmodule

[sv/bbl_avg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbl_avg
// reciprocal multiply per channel and output register
// ----------------------------------------------------------------------------
module bbl_avg import bbl_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic [D_W-1:0]   blur_dist,
	input  avg_req_t         avg_s2,
	output logic             out_valid,
	output logic [PIX_W-1:0] pixel_out,
	output logic             out_last_in_line,
	output logic             out_last_in_frame,
	output logic             last_of_run
);

	logic [RCP_W-1:0]             rcp;
	logic [NUM_CH-1:0][PROD_W-1:0] prod;
	logic [NUM_CH-1:0][CH_W-1:0]   q_s3;
	logic                          vld_s3;
	logic [PIX_W-1:0]              pix_s3;
	logic                          last_s3;
	logic                          lil_s3;
	logic                          lif_s3;
	logic [PIX_W-1:0]              avg_pix;

	assign rcp = recip(blur_dist);

	always_comb begin
		for (int k = 0; k < NUM_CH; k++)
			prod[k] = PROD_W'(avg_s2.sum[k]) * PROD_W'(rcp);
	end

	// pass-through at zero distance, zero pixel when alpha averages to zero
	always_comb begin
		if (blur_dist == '0)
			avg_pix = pix_s3;
		else if (q_s3[NUM_CH-1] == '0)
			avg_pix = '0;
		else
			avg_pix = q_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3    <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			vld_s3    <= avg_s2.vld;
			out_valid <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_CH; k++)
				q_s3[k] <= prod[k][RCP_SH +: CH_W];
			pix_s3            <= avg_s2.pix;
			last_s3           <= avg_s2.last;
			lil_s3            <= avg_s2.lil && avg_s2.last;
			lif_s3            <= avg_s2.lil && avg_s2.lif && avg_s2.last;
			pixel_out         <= avg_pix;
			last_of_run       <= last_s3;
			out_last_in_line  <= lil_s3;
			out_last_in_frame <= lif_s3;
		end
	end

endmodule

[sv/box_blur_line_top.sv]
`timescale 1ns / 1ps
// path: a result reaches the output register through shift_s1, avg_s2 and the s3 registers
// throughput: one window shift per cycle while the output is not stalled; a line's last item is
// followed by d border flush shifts (d = blur distance, saturated at 16), bound by the ram port
// reset: arst_n clears control, config and sums; the window ram is not cleared, a per-line
// fill count marks which entries hold this line's pixels, so no clearing pass is needed
// ----------------------------------------------------------------------------
// box_blur_line_top
// horizontal box blur of a pixel line with configurable window and border
// ----------------------------------------------------------------------------
module box_blur_line_top import bbl_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// input items
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [PIX_W-1:0]   pixel_in,
	input  logic               last_in_line,
	input  logic               last_in_frame,
	// result items
	output logic               out_valid,
	input  logic               out_ready,
	output logic [PIX_W-1:0]   pixel_out,
	output logic               out_last_in_line,
	output logic               out_last_in_frame,
	output logic               last_of_run
);

	logic [DIST_CFG_W-1:0] dist_cfg_q;
	logic [PIX_W-1:0]      border_q;
	logic [D_W-1:0]        blur_dist;
	logic                  en;
	logic [ADDR_W-1:0]     rd_addr;
	logic [PIX_W-1:0]      rd_data;
	logic                  wr_en;
	logic [ADDR_W-1:0]     wr_addr;
	logic [PIX_W-1:0]      wr_data;
	shift_t                shift_s1;
	avg_req_t              avg_s2;

	// register file: write on the access phase, reads are combinational
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_cfg_q <= '0;
			border_q   <= '0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_DIST:   dist_cfg_q <= pwdata[DIST_CFG_W-1:0];
				REG_BORDER: border_q   <= pwdata;
				default:    border_q   <= pwdata;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_DIST:   prdata = {{(32-DIST_CFG_W){1'b0}}, dist_cfg_q};
			REG_BORDER: prdata = border_q;
			default:    prdata = '0;
		endcase
	end

	// distances above the maximum act as the maximum
	assign blur_dist = sat_dist(dist_cfg_q);

	// whole pipeline advances together; it holds while a result waits at the output
	assign en = !out_valid || out_ready;

	// stage 0: intake and flush sequencing, issues one window read per shift
	bbl_seq u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.blur_dist    (blur_dist),
		.border       (border_q),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.pixel_in     (pixel_in),
		.last_in_line (last_in_line),
		.last_in_frame(last_in_frame),
		.rd_addr      (rd_addr),
		.shift_s1     (shift_s1)
	);

	// window store: circular buffer, the entry leaving the window is read as the shift enters
	// shift_s1, ahead of the write of the new pixel from shift_s1
	bbl_ram #(
		.WIDTH(PIX_W),
		.DEPTH(STORE_DEPTH)
	) u_window (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_en  (en),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// stage 1: sum update with forwarding of the write just made
	bbl_sum u_sum (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.shift_s1(shift_s1),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.avg_s2  (avg_s2)
	);

	// stages 2 and 3: divide by window width, then the output register
	bbl_avg u_avg (
		.clk              (clk),
		.arst_n           (arst_n),
		.en               (en),
		.blur_dist        (blur_dist),
		.avg_s2           (avg_s2),
		.out_valid        (out_valid),
		.pixel_out        (pixel_out),
		.out_last_in_line (out_last_in_line),
		.out_last_in_frame(out_last_in_frame),
		.last_of_run      (last_of_run)
	);

endmodule

[sv/bbl_chk.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbl_chk
// port level checks of the box blur, bound to the top level
// ----------------------------------------------------------------------------
module bbl_chk import bbl_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               psel,
	input logic               penable,
	input logic               pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [31:0]        pwdata,
	input logic [31:0]        prdata,
	input logic               pready,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic [PIX_W-1:0]   pixel_out,
	input logic               out_last_in_line,
	input logic               out_last_in_frame,
	input logic               last_of_run
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_out) && $stable(last_of_run))
		else $error("result changed while stalled");

	// a stalled output stops intake
	a_stall_in: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("item taken while output stalled");

	a_frame_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last_in_frame |-> out_last_in_line && last_of_run)
		else $error("frame end without line end");

	a_line_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_last_in_line |-> last_of_run)
		else $error("line end not last of run");

	// border register reads back what was written
	a_border_rb: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready && (paddr[2] == REG_BORDER)
		|=> (paddr[2] != REG_BORDER) || (prdata == $past(pwdata)))
		else $error("border register readback mismatch");

endmodule

bind box_blur_line_top bbl_chk u_bbl_chk (.*);

[bench/tb_box_blur_line_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_line_top
// self-checking bench for the horizontal box blur: pixel lines go in through
// the valid/ready input channel while a local line-blur predictor builds the
// blurred pixels that must come back, in order, on the result channel. the
// blur distance and border pixel are rewritten over the apb port between
// phases, including in the middle of a line
// ----------------------------------------------------------------------------
module tb_box_blur_line_top;
	import bbl_pkg::*;

	localparam int          HALF_PERIOD  = 2;
	localparam int          RESET_CYCLES = 7;
	// results trail their shift through the pipeline registers, a line end adds up to 16 flush shifts
	localparam int          DRAIN_CYCLES = 32;
	localparam int          STALL_LIMIT  = 3000;
	localparam int unsigned PIXEL_GOAL   = 470;

	// register addresses on the apb port
	localparam logic [PADDR_W-1:0] ADDR_DIST   = {REG_DIST, 2'b00};
	localparam logic [PADDR_W-1:0] ADDR_BORDER = {REG_BORDER, 2'b00};

	// one input item
	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             lil;
		logic             lif;
	} line_pixel_t;

	// one result item
	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             lil;
		logic             lif;
		logic             lor;
	} blurred_pixel_t;

	logic               clk               = 1'b0;
	logic               arst_n            = 1'b0;
	logic               psel              = 1'b0;
	logic               penable           = 1'b0;
	logic               pwrite            = 1'b0;
	logic [PADDR_W-1:0] paddr             = '0;
	logic [31:0]        pwdata            = '0;
	logic [31:0]        prdata;
	logic               pready;
	logic               in_valid          = 1'b0;
	logic               in_ready;
	logic [PIX_W-1:0]   pixel_in          = '0;
	logic               last_in_line      = 1'b0;
	logic               last_in_frame     = 1'b0;
	logic               out_valid;
	logic               out_ready         = 1'b0;
	logic [PIX_W-1:0]   pixel_out;
	logic               out_last_in_line;
	logic               out_last_in_frame;
	logic               last_of_run;

	box_blur_line_top uut (
		.clk               (clk),
		.arst_n            (arst_n),
		.psel              (psel),
		.penable           (penable),
		.pwrite            (pwrite),
		.paddr             (paddr),
		.pwdata            (pwdata),
		.prdata            (prdata),
		.pready            (pready),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.pixel_in          (pixel_in),
		.last_in_line      (last_in_line),
		.last_in_frame     (last_in_frame),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.pixel_out         (pixel_out),
		.out_last_in_line  (out_last_in_line),
		.out_last_in_frame (out_last_in_frame),
		.last_of_run       (last_of_run)
	);

	// ------------------------------------------------------------------
	// bench state
	// ------------------------------------------------------------------
	line_pixel_t    pending_pixels [$];   // items waiting for the driver
	blurred_pixel_t blurred_q      [$];   // predicted results, oldest first
	line_pixel_t    cur_item;
	int unsigned    pixels_queued  = 0;
	int unsigned    pixels_taken   = 0;
	int unsigned    results_seen   = 0;
	int unsigned    lines_closed   = 0;
	int unsigned    settings_used  = 0;
	int unsigned    errors         = 0;
	int unsigned    src_gap        = 0;
	int unsigned    snk_stall      = 0;
	int unsigned    quiet_cycles   = 0;
	bit             steady_src     = 1'b0;
	bit             steady_snk     = 1'b0;

	// ------------------------------------------------------------------
	// line-blur predictor: own copy of config, window and channel sums
	// ------------------------------------------------------------------
	logic [DIST_CFG_W-1:0] cfg_dist   = '0;
	logic [PIX_W-1:0]      cfg_border = '0;
	logic [PIX_W-1:0]      win [STORE_DEPTH];
	logic [SUM_W-1:0]      acc [NUM_CH] = '{default: '0};
	int unsigned           win_fill   = 0;     // shifts this line, saturating at d
	bit                    line_fresh = 1'b1;  // next pixel opens a line

	function automatic int unsigned live_dist();
		return (int'(cfg_dist) > MAX_DISTANCE) ? MAX_DISTANCE : int'(cfg_dist);
	endfunction

	// averaged pixel of the current window (the newest pixel at zero distance), zero when the alpha average is zero
	function automatic logic [PIX_W-1:0] box_average(input int unsigned d);
		int unsigned      w;
		logic [PIX_W-1:0] r;
		w = 2 * d + 1;
		if (d == 0)
			return win[STORE_DEPTH-1];
		for (int k = 0; k < NUM_CH; k++)
			r[CH_W*k +: CH_W] = CH_W'(32'(acc[k]) / w);
		if (r[PIX_W-1 -: CH_W] == '0)
			return '0;
		return r;
	endfunction

	// shift one pixel into the window and emit a result once the window is primed
	function automatic void window_shift(input logic [PIX_W-1:0] v, input int unsigned d);
		int unsigned      w;
		bit               emit;
		logic [PIX_W-1:0] oldest;
		blurred_pixel_t   res;
		w      = 2 * d + 1;
		emit   = (win_fill >= d);
		oldest = win[STORE_DEPTH - w];
		for (int k = 0; k < NUM_CH; k++)
			acc[k] = acc[k] + SUM_W'(v[CH_W*k +: CH_W]) - SUM_W'(oldest[CH_W*k +: CH_W]);
		for (int i = 0; i < STORE_DEPTH - 1; i++)
			win[i] = win[i+1];
		win[STORE_DEPTH-1] = v;
		if (win_fill < d)
			win_fill++;
		if (emit) begin
			res     = '0;
			res.pix = box_average(d);
			blurred_q.push_back(res);
		end
	endfunction

	// all results that one accepted item causes
	function automatic void blur_step(input line_pixel_t it);
		int unsigned    d;
		int unsigned    before_cnt;
		blurred_pixel_t tail;
		d          = live_dist();
		before_cnt = blurred_q.size();
		if (line_fresh) begin
			for (int i = 0; i < STORE_DEPTH; i++)
				win[i] = cfg_border;
			for (int k = 0; k < NUM_CH; k++)
				acc[k] = SUM_W'(32'(cfg_border[CH_W*k +: CH_W]) * (2 * d + 1));
			win_fill   = 0;
			line_fresh = 1'b0;
		end
		window_shift(it.pix, d);
		if (it.lil) begin
			// flush the line tail with border pixels
			for (int j = 0; j < d; j++)
				window_shift(cfg_border, d);
			line_fresh = 1'b1;
			lines_closed++;
		end
		if (blurred_q.size() > before_cnt) begin
			tail     = blurred_q.pop_back();
			tail.lor = 1'b1;
			if (it.lil) begin
				tail.lil = 1'b1;
				tail.lif = it.lif;   // frame mark counts only together with the line mark
			end
			blurred_q.push_back(tail);
		end
	endfunction

	// idle length: mostly none or short, now and then long
	function automatic int unsigned idle_len(input bit steady);
		int unsigned r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		return $urandom_range(6, 30);
	endfunction

	// ------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------
	initial begin
		forever #HALF_PERIOD clk = ~clk;
	end

	// ------------------------------------------------------------------
	// input driver: one item at a time from pending_pixels, random gaps
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			// accepted item: predict what it causes
			if (in_valid && in_ready) begin
				blur_step(cur_item);
				pixels_taken++;
			end
			// channel free: either idle for a while or offer the next item
			if (!in_valid || in_ready) begin
				if (src_gap > 0) begin
					src_gap--;
					in_valid <= 1'b0;
				end else if (pending_pixels.size() != 0) begin
					cur_item      = pending_pixels.pop_front();
					pixel_in      <= cur_item.pix;
					last_in_line  <= cur_item.lil;
					last_in_frame <= cur_item.lif;
					in_valid      <= 1'b1;
					src_gap       = idle_len(steady_src);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// result monitor: compare against the oldest prediction, random stalls
	// ------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		blurred_pixel_t got;
		blurred_pixel_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				got = {pixel_out, out_last_in_line, out_last_in_frame, last_of_run};
				results_seen++;
				if (blurred_q.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("%0t: unexpected result pixel_out=%h lil=%b lif=%b lor=%b",
							$realtime, got.pix, got.lil, got.lif, got.lor);
				end else begin
					want = blurred_q.pop_front();
					if (got !== want) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: result %0d mismatch: pixel_out exp %h got %h",
								$realtime, results_seen, want.pix, got.pix);
							$display("  last_in_line exp %b got %b, last_in_frame exp %b got %b",
								want.lil, got.lil, want.lif, got.lif);
							$display("  last_of_run exp %b got %b", want.lor, got.lor);
						end
					end
				end
				snk_stall = idle_len(steady_snk);
			end
			if (snk_stall > 0) begin
				snk_stall--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: cycles without any accepted item or register access
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("%0t: no progress for %0d cycles, %0d results still due",
			$realtime, STALL_LIMIT, blurred_q.size());
		$display("tb_box_blur_line_top: FAIL");
		$finish;
	end

	// ------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------
	// apb write: setup cycle, then access cycle
	task automatic reg_write(input logic [PADDR_W-1:0] addr, input logic [31:0] val);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// wait until every item is taken and every result is back, then let the pipe empty
	task automatic settle();
		while (pixels_taken != pixels_queued || blurred_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// new distance and border, written only while the block is idle
	task automatic set_blur(input logic [DIST_CFG_W-1:0] d, input logic [PIX_W-1:0] b);
		settle();
		reg_write(ADDR_DIST, 32'(d));
		cfg_dist = d;
		reg_write(ADDR_BORDER, b);
		cfg_border = b;
		settings_used++;
	endtask

	task automatic add_item(input logic [PIX_W-1:0] p, input logic lil, input logic lif);
		line_pixel_t it;
		it.pix = p;
		it.lil = lil;
		it.lif = lif;
		pending_pixels.push_back(it);
		pixels_queued++;
	endtask

	function automatic logic [PIX_W-1:0] rand_pixel();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return '1;
			2:       return {8'h00, 24'($urandom)};   // transparent
			3:       return {8'h01, 24'($urandom)};   // alpha just above zero
			default: return $urandom;
		endcase
	endfunction

	// one line of random pixels; an open line carries on into the next phase
	task automatic add_line(input int unsigned len, input bit close);
		bit lil;
		bit lif;
		for (int unsigned i = 0; i < len; i++) begin
			lil = close && (i == len - 1);
			// a frame mark without a line mark is noise the block must ignore
			lif = lil ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 15) == 0);
			add_item(rand_pixel(), lil, lif);
		end
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		logic [DIST_CFG_W-1:0] nd;
		logic [PIX_W-1:0]      nb;
		int unsigned           goal;
		int unsigned           dd;
		int unsigned           len;
		int unsigned           r;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// pass-through: extremes, a stray frame mark, a line end with both marks
		set_blur(5'd0, 32'h1234_5678);
		add_item(32'h0000_0000, 1'b0, 1'b0);
		add_item(32'hFFFF_FFFF, 1'b0, 1'b0);
		add_item(32'h00FF_FFFF, 1'b0, 1'b1);
		add_item(32'h8040_2010, 1'b1, 1'b1);

		// distance above the maximum saturates; transparent border
		set_blur(5'd31, 32'h00FF_FFFF);
		add_item(32'hFFFF_FFFF, 1'b0, 1'b0);
		add_item(32'h0000_0000, 1'b0, 1'b0);
		add_item(32'hFFFF_FFFF, 1'b1, 1'b1);

		// small window with a white border, then a single-pixel line
		set_blur(5'd1, 32'hFFFF_FFFF);
		add_item(32'h0000_0000, 1'b0, 1'b0);
		add_item(32'hFF00_0000, 1'b0, 1'b0);
		add_item(32'h0000_0000, 1'b0, 1'b0);
		add_item(32'hFFFF_FFFF, 1'b0, 1'b0);
		add_item(32'h0101_0101, 1'b1, 1'b0);
		add_item(32'h7F7F_7F7F, 1'b1, 1'b1);

		// largest legal distance, line shorter than the window
		set_blur(5'd16, 32'hFFFF_FFFF);
		add_item(32'h0000_0000, 1'b0, 1'b0);
		add_item(32'hFF80_4020, 1'b1, 1'b0);

		// distance changes in the middle of a line
		set_blur(5'd2, 32'hFF00_0000);
		add_item(32'h0000_0000, 1'b0, 1'b0);
		add_item(32'h00FF_FFFF, 1'b0, 1'b0);
		add_item(32'hFFFF_FFFF, 1'b0, 1'b0);
		set_blur(5'd4, 32'h8080_8080);
		add_item(32'h0102_0304, 1'b0, 1'b0);
		add_item(32'h0A0B_0C0D, 1'b1, 1'b1);

		// random phases: new setting, then mostly complete lines of random pixels
		while (pixels_queued < PIXEL_GOAL) begin
			r = $urandom_range(0, 9);
			case (r)
				0:       nd = 5'd0;
				1:       nd = 5'd16;
				2:       nd = 5'd31;
				3:       nd = DIST_CFG_W'($urandom_range(17, 30));
				4:       nd = 5'd1;
				default: nd = DIST_CFG_W'($urandom_range(1, 15));
			endcase
			r = $urandom_range(0, 9);
			case (r)
				0:       nb = '0;
				1:       nb = '1;
				2:       nb = {8'h00, 24'($urandom)};
				default: nb = $urandom;
			endcase
			set_blur(nd, nb);
			steady_src = ($urandom_range(0, 4) == 0);
			steady_snk = ($urandom_range(0, 4) == 0);
			dd   = live_dist();
			goal = pixels_queued + $urandom_range(15, 45);
			while (pixels_queued < goal) begin
				r = $urandom_range(0, 99);
				if (r < 65)
					len = $urandom_range(1, 2 * dd + 3);
				else if (r < 85)
					len = $urandom_range(1, 3);
				else
					len = $urandom_range(20, 40);
				add_line(len, $urandom_range(0, 9) != 0);
			end
		end
		// close whatever line is still open
		add_line(3, 1'b1);

		settle();
		errors += blurred_q.size();
		if (blurred_q.size() != 0)
			$display("%0d predicted results never arrived", blurred_q.size());

		$display("covered %0d pixels in %0d closed lines under %0d distance/border settings",
			pixels_taken, lines_closed, settings_used);
		$display("checked %0d blurred pixels, %0d errors", results_seen, errors);
		if (errors == 0)
			$display("tb_box_blur_line_top: PASS");
		else
			$display("tb_box_blur_line_top: FAIL");
		$finish;
	end

endmodule
